FILE: design/seconds_to_dos_datetime_top_defines.svh
// ----------------------------------------------------------------------------
// seconds_to_dos_datetime_top_defines
// Assertion macros shared by the checker of the seconds to DOS date-time block.
// ----------------------------------------------------------------------------
`ifndef SECONDS_TO_DOS_DATETIME_TOP_DEFINES_SVH
`define SECONDS_TO_DOS_DATETIME_TOP_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define SDT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define SDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sdt_pkg.sv
// ----------------------------------------------------------------------------
// sdt_pkg
// Types, constants and calendar helpers for the seconds to DOS date-time block.
// ----------------------------------------------------------------------------
package sdt_pkg;

  // Seconds in a day, an hour and a minute. Only the low-order bits of the
  // products that use them are needed, so each is kept just that wide.
  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam logic [5:0]  SecsPerMin  = 6'd60;

  // Reciprocals for division by a constant. The dividend is first shifted
  // right by the power of two in the divisor (7, 4 and 2 bits), multiplied,
  // and the quotient taken from bit 35, 21 and 14 of the product.
  localparam logic [25:0] DayRecip  = 26'd50903317; // 2^35 / 675, rounded up
  localparam logic [13:0] HourRecip = 14'd9321;     // 2^21 / 225, rounded up
  localparam logic [10:0] MinRecip  = 11'd1093;     // 2^14 / 15, rounded up

  // Year offsets counted from 1970.
  localparam logic [7:0] OffDosBase   = 8'd10;  // 1980
  localparam logic [7:0] OffLastPlain = 8'd50;  // 2020
  localparam logic [7:0] OffShifted   = 8'd76;  // 1980 + 66
  localparam logic [7:0] OffCentury   = 8'd130; // 2100, not a leap year

  typedef enum logic [3:0] {
    S_IDLE,
    S_DAY,
    S_TOD,
    S_HOUR,
    S_REM,
    S_MIN,
    S_YEAR,
    S_MONTH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DAY,
    OP_TOD,
    OP_HOUR,
    OP_REM,
    OP_MIN,
    OP_YEAR_STEP,
    OP_MONTH_STEP,
    OP_FINISH
  } op_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    op_t op;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic year_fits;
    logic month_fits;
  } status_t;

  // Leap year test on the offset from 1970 (valid for 1970 to 2199).
  function automatic logic is_leap(input logic [7:0] yoff);
    is_leap = (yoff[1:0] == 2'd2) && (yoff != OffCentury);
  endfunction

  // Length of a month, January is 0.
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    month_len = len;
  endfunction

endpackage

FILE: design/sdt_datapath.sv
// ----------------------------------------------------------------------------
// sdt_datapath
// Reciprocal dividers, calendar walk registers and result registers.
// ----------------------------------------------------------------------------
module sdt_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  sdt_pkg::ctl_t  ctl,
  input  logic [31:0]    in_seconds_count,
  output sdt_pkg::status_t status,
  output logic           out_strobe,
  output logic [30:0]    out_packed_datetime,
  output logic [6:0]     out_year_since_1980,
  output logic [3:0]     out_month_number,
  output logic [4:0]     out_day_of_month,
  output logic [4:0]     out_hour_of_day,
  output logic [5:0]     out_minute_of_hour,
  output logic [4:0]     out_half_seconds
);
  import sdt_pkg::*;

  logic [31:0] secs_r, secs_nxt;
  logic [15:0] days_r, days_nxt;
  logic [16:0] tod_r, tod_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [11:0] rem_r, rem_nxt;
  logic [5:0]  mins_r, mins_nxt;
  logic [7:0]  yoff_r, yoff_nxt;
  logic [3:0]  mon_r, mon_nxt;
  logic        strobe_r;

  logic [30:0] packed_r;
  logic [6:0]  year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic [4:0]  hour_out_r;
  logic [5:0]  minute_r;
  logic [4:0]  half_r;

  logic [50:0] day_prod;
  logic [16:0] day_secs;
  logic [26:0] hour_prod;
  logic [11:0] hour_secs;
  logic [20:0] min_prod;
  logic [5:0]  min_secs;
  logic [5:0]  sec_fin;
  logic        leap;
  logic [8:0]  year_len;
  logic [4:0]  mon_len;
  logic [6:0]  year_fin;
  logic [3:0]  month_fin;
  logic [4:0]  day_fin;
  logic [4:0]  half_fin;

  // Quotients by reciprocal multiplication, one product per cycle.
  assign day_prod  = {26'd0, secs_r[31:7]} * {25'd0, DayRecip};
  assign hour_prod = {14'd0, tod_r[16:4]} * {13'd0, HourRecip};
  assign min_prod  = {11'd0, rem_r[11:2]} * {10'd0, MinRecip};

  // Remainders need only the low bits of quotient times divisor.
  assign day_secs  = {1'b0, days_r} * SecsPerDay;
  assign hour_secs = {7'd0, hour_r} * SecsPerHour;
  assign min_secs  = mins_r * SecsPerMin;
  assign sec_fin   = rem_r[5:0] - min_secs;

  // Year and month lengths for the current position of the walk.
  assign leap     = is_leap(yoff_r);
  assign year_len = leap ? 9'd366 : 9'd365;
  assign mon_len  = month_len(mon_r, leap);

  assign status.year_fits  = (days_r < {7'd0, year_len});
  assign status.month_fits = (days_r < {11'd0, mon_len});

  // Year field: clamp below 1980, zero from 2021 to 2045, 66 years off from 2046.
  always_comb begin
    priority if (yoff_r < OffDosBase) begin
      year_fin = 7'd0;
    end else if (yoff_r <= OffLastPlain) begin
      year_fin = 7'(yoff_r - OffDosBase);
    end else if (yoff_r < OffShifted) begin
      year_fin = 7'd0;
    end else begin
      year_fin = 7'(yoff_r - OffShifted);
    end
  end

  assign month_fin = mon_r + 4'd1;
  assign day_fin   = 5'(days_r + 16'd1);
  assign half_fin  = sec_fin[5:1];

  // Next-value logic for the working registers.
  always_comb begin
    secs_nxt = secs_r;
    days_nxt = days_r;
    tod_nxt  = tod_r;
    hour_nxt = hour_r;
    rem_nxt  = rem_r;
    mins_nxt = mins_r;
    yoff_nxt = yoff_r;
    mon_nxt  = mon_r;
    unique case (ctl.op)
      OP_LOAD: begin
        secs_nxt = in_seconds_count;
        yoff_nxt = 8'd0;
        mon_nxt  = 4'd0;
      end
      OP_DAY: begin
        days_nxt = day_prod[50:35];
      end
      OP_TOD: begin
        tod_nxt = secs_r[16:0] - day_secs;
      end
      OP_HOUR: begin
        hour_nxt = hour_prod[25:21];
      end
      OP_REM: begin
        rem_nxt = tod_r[11:0] - hour_secs;
      end
      OP_MIN: begin
        mins_nxt = min_prod[19:14];
      end
      OP_YEAR_STEP: begin
        days_nxt = days_r - {7'd0, year_len};
        yoff_nxt = yoff_r + 8'd1;
      end
      OP_MONTH_STEP: begin
        days_nxt = days_r - {11'd0, mon_len};
        mon_nxt  = mon_r + 4'd1;
      end
      default: begin
      end
    endcase
  end

  // Working registers carry payload only.
  always_ff @(posedge clk) begin
    secs_r <= secs_nxt;
    days_r <= days_nxt;
    tod_r  <= tod_nxt;
    hour_r <= hour_nxt;
    rem_r  <= rem_nxt;
    mins_r <= mins_nxt;
    yoff_r <= yoff_nxt;
    mon_r  <= mon_nxt;
  end

  // Result registers, loaded when the walk has finished. The year never
  // exceeds 60, so its top bit is always clear and the packed word drops it.
  always_ff @(posedge clk) begin
    if (ctl.op == OP_FINISH) begin
      packed_r   <= {year_fin[5:0], month_fin, day_fin, hour_r, mins_r, half_fin};
      year_r     <= year_fin;
      month_r    <= month_fin;
      day_r      <= day_fin;
      hour_out_r <= hour_r;
      minute_r   <= mins_r;
      half_r     <= half_fin;
    end
  end

  // The strobe marks a result for exactly one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= (ctl.op == OP_FINISH);
    end
  end

  assign out_strobe          = strobe_r;
  assign out_packed_datetime = packed_r;
  assign out_year_since_1980 = year_r;
  assign out_month_number    = month_r;
  assign out_day_of_month    = day_r;
  assign out_hour_of_day     = hour_out_r;
  assign out_minute_of_hour  = minute_r;
  assign out_half_seconds    = half_r;

endmodule

FILE: design/sdt_controller.sv
// ----------------------------------------------------------------------------
// sdt_controller
// Sequencer for the division steps and the year and month walk.
// ----------------------------------------------------------------------------
module sdt_controller (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  sdt_pkg::status_t status,
  output logic             busy,
  output sdt_pkg::ctl_t    ctl
);
  import sdt_pkg::*;

  state_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_DAY;
      S_DAY:   state_nxt = S_TOD;
      S_TOD:   state_nxt = S_HOUR;
      S_HOUR:  state_nxt = S_REM;
      S_REM:   state_nxt = S_MIN;
      S_MIN:   state_nxt = S_YEAR;
      S_YEAR:  if (status.year_fits) state_nxt = S_MONTH;
      S_MONTH: if (status.month_fits) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    ctl.op = OP_NONE;
    unique case (state_r)
      S_IDLE:  ctl.op = start ? OP_LOAD : OP_NONE;
      S_DAY:   ctl.op = OP_DAY;
      S_TOD:   ctl.op = OP_TOD;
      S_HOUR:  ctl.op = OP_HOUR;
      S_REM:   ctl.op = OP_REM;
      S_MIN:   ctl.op = OP_MIN;
      S_YEAR:  ctl.op = status.year_fits ? OP_NONE : OP_YEAR_STEP;
      S_MONTH: ctl.op = status.month_fits ? OP_FINISH : OP_MONTH_STEP;
      default: ctl.op = OP_NONE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/seconds_to_dos_datetime_top.sv
// ----------------------------------------------------------------------------
// seconds_to_dos_datetime_top
// Converts a 32-bit count of seconds since 1970 into a DOS date-time word.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The block then
// stays busy through the steps of reciprocal multiplication (days, time of
// day, hour, seconds within the hour, minute) and a walk of one year, then
// one month, per cycle, with a further step each to find that the year and
// the month fit. The result appears on the out_ ports, marked by out_strobe
// for exactly one cycle, in the cycle in which busy falls; the receiver
// cannot stall it, and a new transaction may start in that same cycle.
module seconds_to_dos_datetime_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_seconds_count,
  output logic        out_strobe,
  output logic [30:0] out_packed_datetime,
  output logic [6:0]  out_year_since_1980,
  output logic [3:0]  out_month_number,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hour_of_day,
  output logic [5:0]  out_minute_of_hour,
  output logic [4:0]  out_half_seconds
);
  import sdt_pkg::*;

  ctl_t    ctl;
  status_t status;

  // Sequencer.
  sdt_controller u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .busy   (busy),
    .ctl    (ctl)
  );

  // Arithmetic and result registers.
  sdt_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .in_seconds_count    (in_seconds_count),
    .status              (status),
    .out_strobe          (out_strobe),
    .out_packed_datetime (out_packed_datetime),
    .out_year_since_1980 (out_year_since_1980),
    .out_month_number    (out_month_number),
    .out_day_of_month    (out_day_of_month),
    .out_hour_of_day     (out_hour_of_day),
    .out_minute_of_hour  (out_minute_of_hour),
    .out_half_seconds    (out_half_seconds)
  );

endmodule

FILE: design/sdt_checker.sv
// ----------------------------------------------------------------------------
// sdt_checker
// Port-level checks of the seconds to DOS date-time block.
// ----------------------------------------------------------------------------
`include "seconds_to_dos_datetime_top_defines.svh"

module sdt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic [30:0] out_packed_datetime,
  input logic [6:0]  out_year_since_1980,
  input logic [3:0]  out_month_number,
  input logic [4:0]  out_day_of_month,
  input logic [4:0]  out_hour_of_day,
  input logic [5:0]  out_minute_of_hour,
  input logic [4:0]  out_half_seconds
);

  logic packed_ok;
  logic ranges_ok;

  // The packed word carries the low six year bits; the year never exceeds 60.
  assign packed_ok = (out_packed_datetime == {out_year_since_1980[5:0], out_month_number,
                                              out_day_of_month, out_hour_of_day,
                                              out_minute_of_hour, out_half_seconds});
  assign ranges_ok = (out_year_since_1980 <= 7'd60) &&
                     (out_month_number >= 4'd1) && (out_month_number <= 4'd12) &&
                     (out_day_of_month != 5'd0) && (out_hour_of_day <= 5'd23) &&
                     (out_minute_of_hour <= 6'd59) && (out_half_seconds <= 5'd29);

  // An accepted transaction keeps the block busy.
  `SDT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "busy not raised after start")

  // A result appears whenever the block finishes a transaction.
  `SDT_ASSERT_NOW(a_done_result, clk, rst_n, !busy && $past(busy), out_strobe, "finish without result")

  // Results never come in consecutive cycles.
  `SDT_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_strobe, !out_strobe, "result strobe repeated")

  // The packed word agrees with the separate fields and the fields are in range.
  `SDT_ASSERT_NOW(a_fields, clk, rst_n, out_strobe, packed_ok && ranges_ok, "inconsistent result fields")

endmodule

bind seconds_to_dos_datetime_top sdt_checker u_sdt_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_strobe          (out_strobe),
  .out_packed_datetime (out_packed_datetime),
  .out_year_since_1980 (out_year_since_1980),
  .out_month_number    (out_month_number),
  .out_day_of_month    (out_day_of_month),
  .out_hour_of_day     (out_hour_of_day),
  .out_minute_of_hour  (out_minute_of_hour),
  .out_half_seconds    (out_half_seconds)
);

FILE: bench/seconds_to_dos_datetime_checker.sv
// ----------------------------------------------------------------------------
// seconds_to_dos_datetime_checker
// Watches the command and result channels of the seconds to DOS date-time
// block, predicts each result from the accepted transaction and compares the
// two field by field.
// ----------------------------------------------------------------------------
module seconds_to_dos_datetime_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] in_seconds_count,
  input  logic        out_strobe,
  input  logic [30:0] out_packed_datetime,
  input  logic [6:0]  out_year_since_1980,
  input  logic [3:0]  out_month_number,
  input  logic [4:0]  out_day_of_month,
  input  logic [4:0]  out_hour_of_day,
  input  logic [5:0]  out_minute_of_hour,
  input  logic [4:0]  out_half_seconds,
  output int          mismatch_count,
  output int          awaiting_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // One predicted date-time result.
  typedef struct packed {
    logic [30:0] packed_datetime;
    logic [6:0]  year_since_1980;
    logic [3:0]  month_number;
    logic [4:0]  day_of_month;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [4:0]  half_seconds;
  } dos_stamp_t;

  dos_stamp_t pending_stamps[$];

  initial begin
    mismatch_count = 0;
    awaiting_count = 0;
  end

  // Works out the DOS date-time of a seconds count. The day count is walked
  // a month at a time from January 1970 with the full Gregorian leap rules.
  function automatic dos_stamp_t convert_seconds(input logic [31:0] secs);
    dos_stamp_t  stamp;
    int unsigned days;
    int unsigned tod;
    int unsigned year;
    int unsigned month;
    int unsigned month_days;
    int unsigned since_1980;
    logic [31:0] word;
    bit          settled;
    days    = secs / 86400;
    tod     = secs % 86400;
    year    = 1970;
    month   = 0;
    settled = 1'b0;
    while (!settled) begin
      case (month)
        1:          month_days = ((year % 4 == 0) && ((year % 100 != 0) ||
                                  (year % 400 == 0))) ? 29 : 28;
        3, 5, 8, 10: month_days = 30;
        default:    month_days = 31;
      endcase
      if (days < month_days) begin
        settled = 1'b1;
      end else begin
        days = days - month_days;
        if (month == 11) begin
          month = 0;
          year  = year + 1;
        end else begin
          month = month + 1;
        end
      end
    end

    // Early years clamp to 1980; years after 2020 are taken 66 years back.
    if (year < 1980) year = 1980;
    if (year > 2020) year = year - 66;
    since_1980 = (year < 1980) ? 0 : year - 1980;

    stamp.year_since_1980 = since_1980[6:0];
    stamp.month_number    = 4'(month + 1);
    stamp.day_of_month    = 5'(days + 1);
    stamp.hour_of_day     = 5'(tod / 3600);
    stamp.minute_of_hour  = 6'((tod % 3600) / 60);
    stamp.half_seconds    = 5'((tod % 60) / 2);
    word = {stamp.year_since_1980, stamp.month_number, stamp.day_of_month,
            stamp.hour_of_day, stamp.minute_of_hour, stamp.half_seconds};
    stamp.packed_datetime = word[30:0];
    return stamp;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Results are retired before new transactions are queued, so a result and
  // a fresh command in the same cycle keep their order.
  always @(posedge clk) begin
    dos_stamp_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (pending_stamps.size() == 0) begin
          $error("unexpected result: packed_datetime %h", out_packed_datetime);
          mismatch_count++;
        end else begin
          want = pending_stamps.pop_front();
          check_field("packed_datetime", want.packed_datetime, out_packed_datetime);
          check_field("year_since_1980", want.year_since_1980, out_year_since_1980);
          check_field("month_number", want.month_number, out_month_number);
          check_field("day_of_month", want.day_of_month, out_day_of_month);
          check_field("hour_of_day", want.hour_of_day, out_hour_of_day);
          check_field("minute_of_hour", want.minute_of_hour, out_minute_of_hour);
          check_field("half_seconds", want.half_seconds, out_half_seconds);
        end
      end
      if (start && !busy) begin
        pending_stamps.push_back(convert_seconds(in_seconds_count));
      end
      awaiting_count = pending_stamps.size();
    end
  end

endmodule

FILE: bench/seconds_to_dos_datetime_top_test.sv
// ----------------------------------------------------------------------------
// seconds_to_dos_datetime_top_test
// Drives the seconds to DOS date-time block with calendar corner cases and
// then random counts, many aimed at day and year boundaries, with random idle
// stretches, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module seconds_to_dos_datetime_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems   = 1830;
  localparam int QuietFirst    = 700;
  localparam int QuietLast     = 1100;
  localparam int DrainPoint    = 900;
  localparam int DrainCycles   = 250;
  localparam int CycleLimit    = 3_000_000;
  localparam int GapChance     = 20;
  localparam int LongestGap    = 190;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [31:0] in_seconds_count = '0;
  logic        busy;
  logic        out_strobe;
  logic [30:0] out_packed_datetime;
  logic [6:0]  out_year_since_1980;
  logic [3:0]  out_month_number;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hour_of_day;
  logic [5:0]  out_minute_of_hour;
  logic [4:0]  out_half_seconds;
  int          mismatch_count;
  int          awaiting_count;
  int          cycle_count = 0;
  bit          gaps_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  seconds_to_dos_datetime_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_seconds_count    (in_seconds_count),
    .out_strobe          (out_strobe),
    .out_packed_datetime (out_packed_datetime),
    .out_year_since_1980 (out_year_since_1980),
    .out_month_number    (out_month_number),
    .out_day_of_month    (out_day_of_month),
    .out_hour_of_day     (out_hour_of_day),
    .out_minute_of_hour  (out_minute_of_hour),
    .out_half_seconds    (out_half_seconds)
  );

  seconds_to_dos_datetime_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_seconds_count    (in_seconds_count),
    .out_strobe          (out_strobe),
    .out_packed_datetime (out_packed_datetime),
    .out_year_since_1980 (out_year_since_1980),
    .out_month_number    (out_month_number),
    .out_day_of_month    (out_day_of_month),
    .out_hour_of_day     (out_hour_of_day),
    .out_minute_of_hour  (out_minute_of_hour),
    .out_half_seconds    (out_half_seconds),
    .mismatch_count      (mismatch_count),
    .awaiting_count      (awaiting_count)
  );

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("seconds_to_dos_datetime_top test failed");
      $finish;
    end
  end

  // Issues one transaction. Called and returns at a falling edge; an
  // optional idle stretch comes first, so start is never dropped and raised
  // in the same step.
  task automatic send_seconds(input logic [31:0] value);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(99) < GapChance) gap = $urandom_range(LongestGap, 1);
    if (gap > 0) begin
      start            <= 1'b0;
      in_seconds_count <= $urandom;
      repeat (gap) @(negedge clk);
    end
    start            <= 1'b1;
    in_seconds_count <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Holds the sender off until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (awaiting_count != 0) @(negedge clk);
  endtask

  initial begin
    int          i;
    int          pick;
    int          year;
    int          y;
    longint      stamp;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Field extremes and calendar corners.
    send_seconds(32'd0);           // start of the epoch
    send_seconds(32'hFFFF_FFFF);   // largest count, early 2106
    send_seconds(32'hAAAA_AAAA);
    send_seconds(32'h5555_5555);
    send_seconds(32'd86399);       // last second of the first day
    send_seconds(32'd2678399);     // end of January 1970
    send_seconds(32'd2678400);     // first of February 1970
    send_seconds(32'd68169600);    // 29 February 1972
    send_seconds(32'd315532799);   // last second before 1980, clamped
    send_seconds(32'd315532800);   // first second of 1980
    send_seconds(32'd951782400);   // 29 February 2000, a century leap year
    send_seconds(32'd1609459199);  // last second of 2020
    send_seconds(32'd1609459200);  // 2021, the year field saturates to zero
    send_seconds(32'd2398377599);  // end of 2045, still saturated
    send_seconds(32'd2398377600);  // 2046 maps back to 1980
    send_seconds(32'd2429913600);  // 2047 maps to 1981
    send_seconds(32'd4107542399);  // 28 February 2100, not a leap year
    send_seconds(32'd4107542400);  // 1 March 2100
    drain_results();

    // Random counts, many of them near day and year boundaries.
    for (i = 0; i < RandomItems; i++) begin
      gaps_on = (i < QuietFirst) || (i >= QuietLast);
      if (i == DrainPoint) drain_results();
      pick = $urandom_range(99);
      if (pick < 45) begin
        stamp = $urandom;
      end else if (pick < 70) begin
        stamp = longint'($urandom_range(49710)) * 86400;
        case ($urandom_range(3))
          0:       stamp = stamp + 86399;
          1:       stamp = stamp + $urandom_range(86399);
          2:       stamp = stamp - 1;
          default: ;
        endcase
      end else if (pick < 90) begin
        year  = $urandom_range(2105, 1970);
        stamp = 0;
        for (y = 1970; y < year; y++) begin
          stamp = stamp + (((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0)))
                           ? 366 : 365);
        end
        stamp = stamp * 86400 + longint'($urandom_range(7200)) - 3600;
      end else begin
        stamp = $urandom_range(32'd2556144000, 32'd315532800);
      end
      send_seconds(stamp[31:0]);
    end

    // Let the last results arrive, then allow for any stragglers.
    start <= 1'b0;
    @(negedge clk);
    while (awaiting_count != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (mismatch_count == 0 && awaiting_count == 0) begin
      $display("seconds_to_dos_datetime_top test passed");
    end else begin
      $display("seconds_to_dos_datetime_top test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/sdt_pkg.sv
design/sdt_datapath.sv
design/sdt_controller.sv
design/seconds_to_dos_datetime_top.sv
design/sdt_checker.sv
bench/seconds_to_dos_datetime_checker.sv
bench/seconds_to_dos_datetime_top_test.sv
